>>> rtl/rfp_pkg.sv
`default_nettype none

package rfp_pkg;

  // Relocation kind codes carried in the func field.
  typedef enum logic [4:0] {
    FN_NONE    = 5'd0,
    FN_R6      = 5'd1,
    FN_R8      = 5'd2,
    FN_R9      = 5'd3,
    FN_R10     = 5'd4,
    FN_R11     = 5'd5,
    FN_R12     = 5'd6,
    FN_R16X    = 5'd7,
    FN_TPREL16 = 5'd8,
    FN_WORD32  = 5'd9,
    FN_X32_6   = 5'd10,
    FN_B9      = 5'd11,
    FN_B9X     = 5'd12,
    FN_B13     = 5'd13,
    FN_B15     = 5'd14,
    FN_B15X    = 5'd15,
    FN_B22     = 5'd16,
    FN_B22X    = 5'd17,
    FN_HI16    = 5'd18,
    FN_LO16    = 5'd19
  } func_e;

  // Every scatter mask the block can apply, named by its bit pattern.
  typedef enum logic [4:0] {
    MK_NONE,
    MK_ALL,
    MK_03F00000,
    MK_0000201F,
    MK_00001F80,
    MK_000020F8,
    MK_000007E0,
    MK_001F2000,
    MK_00000F60,
    MK_001F0100,
    MK_0000003F,
    MK_00030078,
    MK_006020E0,
    MK_061F20FF,
    MK_061F3FE0,
    MK_00DF3FE0,
    MK_0FE03FE0,
    MK_00001FE0,
    MK_00E020E8,
    MK_0000207F,
    MK_00003FE0,
    MK_00203FE0,
    MK_060020FF,
    MK_06003FE0,
    MK_0FFF3FFF,
    MK_003000FE,
    MK_00202FFE,
    MK_00DF20FE,
    MK_01FF3FFE,
    MK_00C03FFF
  } mask_e;

  localparam logic [31:0] PARSE_BITS  = 32'h0000c000;
  localparam logic [31:0] DUPLEX_MASK = 32'h03f00000;

  typedef struct packed {
    logic [4:0]         func;
    logic [31:0]        insn;
    logic signed [63:0] value;
  } rfp_in_t;

  typedef struct packed {
    logic [31:0] patched_word;
    logic        range_error;
    logic        unknown_opcode;
  } rfp_out_t;

  // Bit deposit. Always called with a constant mask, so it reduces to wiring.
  function automatic logic [31:0] deposit(input logic [31:0] mask, input logic [31:0] data);
    logic [31:0] res;
    logic [5:0]  pos;
    res = '0;
    pos = '0;
    for (int b = 0; b < 32; b++) begin
      if (mask[b]) begin
        res[b] = data[pos[4:0]];
        pos    = pos + 6'd1;
      end
    end
    return res;
  endfunction

  // Scatter the data under the selected mask; each arm has a fixed pattern.
  function automatic logic [31:0] apply_mask(input mask_e sel, input logic [31:0] data);
    logic [31:0] res;
    case (sel)
      MK_ALL:      res = data;
      MK_03F00000: res = deposit(DUPLEX_MASK, data);
      MK_0000201F: res = deposit(32'h0000201f, data);
      MK_00001F80: res = deposit(32'h00001f80, data);
      MK_000020F8: res = deposit(32'h000020f8, data);
      MK_000007E0: res = deposit(32'h000007e0, data);
      MK_001F2000: res = deposit(32'h001f2000, data);
      MK_00000F60: res = deposit(32'h00000f60, data);
      MK_001F0100: res = deposit(32'h001f0100, data);
      MK_0000003F: res = deposit(32'h0000003f, data);
      MK_00030078: res = deposit(32'h00030078, data);
      MK_006020E0: res = deposit(32'h006020e0, data);
      MK_061F20FF: res = deposit(32'h061f20ff, data);
      MK_061F3FE0: res = deposit(32'h061f3fe0, data);
      MK_00DF3FE0: res = deposit(32'h00df3fe0, data);
      MK_0FE03FE0: res = deposit(32'h0fe03fe0, data);
      MK_00001FE0: res = deposit(32'h00001fe0, data);
      MK_00E020E8: res = deposit(32'h00e020e8, data);
      MK_0000207F: res = deposit(32'h0000207f, data);
      MK_00003FE0: res = deposit(32'h00003fe0, data);
      MK_00203FE0: res = deposit(32'h00203fe0, data);
      MK_060020FF: res = deposit(32'h060020ff, data);
      MK_06003FE0: res = deposit(32'h06003fe0, data);
      MK_0FFF3FFF: res = deposit(32'h0fff3fff, data);
      MK_003000FE: res = deposit(32'h003000fe, data);
      MK_00202FFE: res = deposit(32'h00202ffe, data);
      MK_00DF20FE: res = deposit(32'h00df20fe, data);
      MK_01FF3FFE: res = deposit(32'h01ff3ffe, data);
      MK_00C03FFF: res = deposit(32'h00c03fff, data);
      default:     res = '0;
    endcase
    return res;
  endfunction

  // Opcode table shared by the r6 and r16 decodes; MK_NONE means not found.
  function automatic mask_e op_table(input logic [7:0] op);
    mask_e m;
    case (op)
      8'h38, 8'h39:                      m = MK_0000201F;
      8'h3e, 8'h3f, 8'h6a:               m = MK_00001F80;
      8'h40, 8'h42, 8'h44, 8'h46:        m = MK_000020F8;
      8'h41, 8'h43, 8'h45, 8'h47:        m = MK_000007E0;
      8'h7c:                             m = MK_001F2000;
      8'h9a, 8'h9b, 8'h9c, 8'h9d:        m = MK_00000F60;
      8'h9f:                             m = MK_001F0100;
      8'hab, 8'had:                      m = MK_0000003F;
      8'haf:                             m = MK_00030078;
      8'hd7, 8'hd8, 8'hdb, 8'hdf:        m = MK_006020E0;
      default:                           m = MK_NONE;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rfp_patch.sv
`default_nettype none

module rfp_patch (
  input  wire rfp_pkg::rfp_in_t item_i,
  output rfp_pkg::rfp_out_t     result_o
);
  import rfp_pkg::*;

  logic [7:0]  op;
  logic        duplex;
  logic [63:0] v;
  logic [31:0] data;
  logic [31:0] add;
  mask_e       sel;
  mask_e       r16_sel;
  logic        rerr;
  logic        unk;

  assign op     = item_i.insn[31:24];
  assign duplex = (item_i.insn & PARSE_BITS) == 32'h0;
  assign v      = item_i.value;

  // True when the value's bits from n-1 upward are not all equal.
  function automatic logic out_of_range(input logic [63:0] val, input int n);
    logic [63:0] upper;
    upper = $signed(val) >>> (n - 1);
    return !((upper == 64'h0) || (upper == '1));
  endfunction

  always_comb begin
    if (duplex) begin
      r16_sel = MK_03F00000;
    end else begin
      case (op)
        8'h48:   r16_sel = MK_061F20FF;
        8'h49:   r16_sel = MK_061F3FE0;
        8'h78:   r16_sel = MK_00DF3FE0;
        8'hb0:   r16_sel = MK_0FE03FE0;
        8'h74:   r16_sel = MK_00001FE0;
        default: r16_sel = op_table(op);
      endcase
    end
  end

  always_comb begin
    sel  = MK_NONE;
    data = v[31:0];
    rerr = 1'b0;
    unk  = 1'b0;
    case (item_i.func)
      FN_R6: begin
        sel = duplex ? MK_03F00000 : op_table(op);
        unk = (sel == MK_NONE);
      end
      FN_R8: begin
        if (op == 8'hde) begin
          sel = MK_00E020E8;
        end else if (op == 8'h3c) begin
          sel = MK_0000207F;
        end else begin
          sel = MK_00001FE0;
        end
      end
      FN_R9: begin
        sel  = MK_00003FE0;
        data = {26'h0, v[5:0]};
      end
      FN_R10: begin
        sel  = MK_00203FE0;
        data = {26'h0, v[5:0]};
      end
      FN_R11: begin
        sel  = (op == 8'ha1) ? MK_060020FF : MK_06003FE0;
        data = {26'h0, v[5:0]};
      end
      FN_R12: sel = MK_000007E0;
      FN_R16X: begin
        sel  = r16_sel;
        data = {26'h0, v[5:0]};
        unk  = (r16_sel == MK_NONE);
      end
      FN_TPREL16: begin
        sel  = r16_sel;
        data = {16'h0, v[15:0]};
        unk  = (r16_sel == MK_NONE);
      end
      FN_WORD32: sel = MK_ALL;
      FN_X32_6: begin
        sel  = MK_0FFF3FFF;
        data = v[37:6];
      end
      FN_B9: begin
        sel  = MK_003000FE;
        data = v[33:2];
        rerr = out_of_range(v, 11);
      end
      FN_B9X: begin
        sel  = MK_003000FE;
        data = {26'h0, v[5:0]};
      end
      FN_B13: begin
        sel  = MK_00202FFE;
        data = v[33:2];
        rerr = out_of_range(v, 15);
      end
      FN_B15: begin
        sel  = MK_00DF20FE;
        data = v[33:2];
        rerr = out_of_range(v, 17);
      end
      FN_B15X: begin
        sel  = MK_00DF20FE;
        data = {26'h0, v[5:0]};
      end
      FN_B22: begin
        sel  = MK_01FF3FFE;
        data = v[33:2];
        rerr = out_of_range(v, 24);
      end
      FN_B22X: begin
        sel  = MK_01FF3FFE;
        data = {26'h0, v[5:0]};
      end
      FN_HI16: begin
        sel  = MK_00C03FFF;
        data = v[47:16];
      end
      FN_LO16: sel = MK_00C03FFF;
      default: sel = MK_NONE;
    endcase
  end

  assign add = apply_mask(sel, data);

  assign result_o.patched_word   = item_i.insn | add;
  assign result_o.range_error    = rerr;
  assign result_o.unknown_opcode = unk;

endmodule

`default_nettype wire

>>> rtl/isa_relocation_field_patcher.sv
`default_nettype none

// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    in_data_i  (rfp_in_t: func, insn, value)
// out      output     out_valid_o / out_ready_i  out_data_o (rfp_out_t: word, two flags)
//
// Each beat passes through two registers: an input register and a result register,
// with the mask decode and bit deposit in between. One beat can be taken every cycle
// while the output is not stalled; the rate is set by the single decode-and-deposit
// path. When the output stalls, each stage holds its beat and the input register
// still accepts a beat while it is empty. Reset empties both stages.

module isa_relocation_field_patcher (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire rfp_pkg::rfp_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output rfp_pkg::rfp_out_t      out_data_o
);
  import rfp_pkg::*;

  // Input stage.
  logic     s1_valid_q, s1_valid_d;
  rfp_in_t  s1_data_q;
  // Result stage.
  logic     s2_valid_q, s2_valid_d;
  rfp_out_t s2_data_q;
  rfp_out_t patch_result;

  logic s2_load;
  logic s1_load;

  // The result register takes a new beat when it is empty or being drained.
  assign s2_load    = !s2_valid_q || out_ready_i;
  // The input register can refill when its beat moves on or when it is empty.
  assign in_ready_o = !s1_valid_q || s2_load;
  assign s1_load    = in_valid_i && in_ready_o;

  assign s1_valid_d = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_q);
  assign s2_valid_d = s2_load ? s1_valid_q : s2_valid_q;

  rfp_patch u_patch (
    .item_i   (s1_data_q),
    .result_o (patch_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_data_q <= in_data_i;
    end
    if (s2_load && s1_valid_q) begin
      s2_data_q <= patch_result;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_data_q;

endmodule

`default_nettype wire
